// ===== rtl/fcull_pkg.sv =====
// ----------------------------------------------------------------------------
// Frustum culling test package
// Shared constants, field widths and item kind codes for the plane test block.
// ----------------------------------------------------------------------------
package fcull_pkg;

  localparam int unsigned NUM_PLANES_DEF  = 6;
  localparam int unsigned COORD_WIDTH_DEF = 32;

  // Coordinates and coefficients are Q16.16.
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned MOUT_W  = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_POINT  = 2'd1,
    MODE_SPHERE = 2'd2,
    MODE_BOX    = 2'd3
  } mode_t;

endpackage

// ===== rtl/frustum_culling_test.sv =====
// ----------------------------------------------------------------------------
// Frustum culling test
// Holds the clipping planes and tests points, spheres and boxes against them.
// ----------------------------------------------------------------------------
// A test result passes the read, multiply and result registers.
// A sweep reads one plane per cycle from the single-port plane store; no new item
// is taken until the sweep is done and its result is in the result register.
// The result register lets the next item in while the last result waits.
// Reset clears the per-plane valid bits, so an unloaded plane reads as all
// zero coefficients; there is no clearing pass.
module frustum_culling_test
  import fcull_pkg::*;
#(
  parameter int unsigned NUM_PLANES  = NUM_PLANES_DEF,
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  localparam int unsigned IN_W = ((10 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // plane_index, plane_a, plane_b, plane_c, plane_d, pos_x, pos_y, pos_z,
  // half_x, half_y, half_z (lowest bits first)
  input  logic [IN_W-1:0]   s_axis_tdata,
  // mode
  input  logic [MODE_W-1:0] s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // inside_res
  output logic [MOUT_W-1:0] m_axis_tdata
);

  localparam int unsigned CW      = COORD_WIDTH;
  localparam int unsigned HW      = COORD_WIDTH - 1;
  localparam int unsigned IDX_W   = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int unsigned PLANE_W = 4 * CW;
  localparam int unsigned PROD_W  = 2 * CW + 1;
  localparam int unsigned K_W     = CW + FRAC_BITS + 1;
  localparam int unsigned SUM_W   = 2 * CW + 3;
  localparam int unsigned H_OFS   = INDEX_W + 7 * CW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Input fields
  logic        [INDEX_W-1:0] in_index;
  logic signed [CW-1:0]      in_a, in_b, in_c, in_d;
  logic signed [CW-1:0]      in_px, in_py, in_pz;
  logic        [HW-1:0]      in_hx, in_hy, in_hz;
  mode_t                     in_mode;
  logic                      s_xfer;
  logic                      wr_ok;

  assign in_index = s_axis_tdata[INDEX_W-1:0];
  assign in_a     = s_axis_tdata[INDEX_W + 0 * CW +: CW];
  assign in_b     = s_axis_tdata[INDEX_W + 1 * CW +: CW];
  assign in_c     = s_axis_tdata[INDEX_W + 2 * CW +: CW];
  assign in_d     = s_axis_tdata[INDEX_W + 3 * CW +: CW];
  assign in_px    = s_axis_tdata[INDEX_W + 4 * CW +: CW];
  assign in_py    = s_axis_tdata[INDEX_W + 5 * CW +: CW];
  assign in_pz    = s_axis_tdata[INDEX_W + 6 * CW +: CW];
  assign in_hx    = s_axis_tdata[H_OFS + 0 * HW +: HW];
  assign in_hy    = s_axis_tdata[H_OFS + 1 * HW +: HW];
  assign in_hz    = s_axis_tdata[H_OFS + 2 * HW +: HW];
  assign in_mode  = mode_t'(s_axis_tuser);

  assign s_axis_tready = (state == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign wr_ok = ({1'b0, in_index} < (INDEX_W + 1)'(NUM_PLANES));

  // Plane store and its valid bits
  logic [PLANE_W-1:0]    plane_mem [NUM_PLANES];
  logic [NUM_PLANES-1:0] loaded;

  always_ff @(posedge clk) begin
    if (s_xfer && in_mode == MODE_LOAD && wr_ok) begin
      plane_mem[in_index[IDX_W-1:0]] <= {in_d, in_c, in_b, in_a};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (s_xfer && in_mode == MODE_LOAD && wr_ok) begin
      loaded[in_index[IDX_W-1:0]] <= 1'b1;
    end
  end

  // Test item held for the whole sweep
  mode_t                t_mode;
  logic signed [CW-1:0] t_px, t_py, t_pz;
  logic        [HW-1:0] t_hx, t_hy, t_hz;

  always_ff @(posedge clk) begin
    if (s_xfer && in_mode != MODE_LOAD) begin
      t_mode <= in_mode;
      t_px   <= in_px;
      t_py   <= in_py;
      t_pz   <= in_pz;
      t_hx   <= in_hx;
      t_hy   <= in_hy;
      t_hz   <= in_hz;
    end
  end

  // Plane sweep counter
  logic [IDX_W-1:0] cnt;
  logic             cnt_last;

  assign cnt_last = (cnt == IDX_W'(NUM_PLANES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_READ) begin
      cnt <= cnt_last ? '0 : cnt + 1'b1;
    end
  end

  // Read stage
  logic [PLANE_W-1:0] rd_word;
  logic               rd_ok, rd_v, rd_first, rd_last;

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_word <= plane_mem[cnt];
    end
    rd_ok    <= loaded[cnt];
    rd_first <= (cnt == '0);
    rd_last  <= cnt_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
    end else begin
      rd_v <= (state == ST_READ);
    end
  end

  // Multiply stage. For a box, a*x + |a|*hx equals a*(x + sign(a)*hx), so
  // each axis needs one product whatever the mode.
  logic signed [CW-1:0]     pa, pb, pc, pd;
  logic signed [CW:0]       ex, ey, ez;
  logic signed [K_W-1:0]    k_d, k_r;
  logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic signed [K_W-1:0]    k_term;
  logic                     mul_v, mul_first, mul_last;
  logic                     is_box, is_sphere;

  assign pa = rd_ok ? rd_word[0 * CW +: CW] : '0;
  assign pb = rd_ok ? rd_word[1 * CW +: CW] : '0;
  assign pc = rd_ok ? rd_word[2 * CW +: CW] : '0;
  assign pd = rd_ok ? rd_word[3 * CW +: CW] : '0;

  assign is_box    = (t_mode == MODE_BOX);
  assign is_sphere = (t_mode == MODE_SPHERE);

  always_comb begin
    ex = $signed({t_px[CW-1], t_px});
    ey = $signed({t_py[CW-1], t_py});
    ez = $signed({t_pz[CW-1], t_pz});
    if (is_box) begin
      ex = pa[CW-1] ? ex - $signed({2'b00, t_hx}) : ex + $signed({2'b00, t_hx});
      ey = pb[CW-1] ? ey - $signed({2'b00, t_hy}) : ey + $signed({2'b00, t_hy});
      ez = pc[CW-1] ? ez - $signed({2'b00, t_hz}) : ez + $signed({2'b00, t_hz});
    end
  end

  assign k_d = K_W'($signed({pd, {FRAC_BITS{1'b0}}}));
  assign k_r = $signed(K_W'({t_hx, {FRAC_BITS{1'b0}}}));

  always_ff @(posedge clk) begin
    prod_x    <= PROD_W'(pa) * PROD_W'(ex);
    prod_y    <= PROD_W'(pb) * PROD_W'(ey);
    prod_z    <= PROD_W'(pc) * PROD_W'(ez);
    k_term    <= is_sphere ? k_d + k_r : k_d;
    mul_first <= rd_first;
    mul_last  <= rd_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_v <= 1'b0;
    end else begin
      mul_v <= rd_v;
    end
  end

  // Sum stage: the sign of the full-width distance decides the plane.
  logic signed [SUM_W-1:0] plane_dist;
  logic                    dist_neg;
  logic                    inside_acc;
  logic                    inside_final;
  logic                    res_pend;
  logic                    out_free;
  logic                    out_load;

  assign plane_dist = SUM_W'(prod_x) + SUM_W'(prod_y) + SUM_W'(prod_z) + SUM_W'(k_term);
  assign dist_neg     = plane_dist[SUM_W-1];
  assign inside_final = (mul_first || inside_acc) && !dist_neg;

  always_ff @(posedge clk) begin
    if (mul_v) begin
      inside_acc <= inside_final;
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = out_free && ((mul_v && mul_last) || state == ST_HOLD);

  always_ff @(posedge clk) begin
    if (mul_v && mul_last && !out_free) begin
      res_pend <= inside_final;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {(MOUT_W - 1)'(0), (state == ST_HOLD) ? res_pend : inside_final};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_xfer && in_mode != MODE_LOAD) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (cnt_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mul_v && mul_last) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Checks
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (!rd_v && !mul_v))
    else $error("new item taken while a sweep is still in the pipeline");

  a_mul_follows_read: assert property (@(posedge clk) disable iff (rst)
    mul_v |-> $past(rd_v))
    else $error("multiply stage valid without a plane read");

  a_finish: assert property (@(posedge clk) disable iff (rst)
    (mul_v && mul_last) |=> ((state == ST_IDLE && m_axis_tvalid) || state == ST_HOLD))
    else $error("finished test neither delivered nor held");

  a_load_no_sweep: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && in_mode == MODE_LOAD) |=> (state == ST_IDLE && !rd_v))
    else $error("load item started a plane sweep");

  a_hold_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> m_axis_tvalid)
    else $error("result held although the output register is free");

endmodule

// ===== verif/frustum_culling_test_tb.sv =====
// ----------------------------------------------------------------------------
// Frustum culling test bench
// Loads clipping planes and streams point, sphere and box tests into the
// block. A plane-store model in the bench works out the expected inside flag
// of each test at its input transfer. The monitor checks every result
// transfer against the oldest waiting flag, under varied input and output
// pacing.
// ----------------------------------------------------------------------------
module frustum_culling_test_tb;
  import fcull_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPL       = NUM_PLANES_DEF;
  localparam int unsigned CW        = COORD_WIDTH_DEF;
  localparam int unsigned DATA_W    = ((10 * CW + 7) / 8) * 8;
  localparam int unsigned MAX_CYC   = 600000;
  localparam int unsigned PHASE_NUM = 4;
  localparam int unsigned PHASE_RND = 345;

  typedef struct {
    mode_t                  mode;
    logic [INDEX_W-1:0]     idx;
    logic signed [CW-1:0]   pa, pb, pc, pd;
    logic signed [CW-1:0]   px, py, pz;
    logic [CW-2:0]          hx, hy, hz;
  } test_item_t;

  typedef struct {
    logic signed [CW-1:0] a, b, c, d;
  } plane_coef_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0] s_axis_tuser = MODE_LOAD;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [MOUT_W-1:0] m_axis_tdata;

  test_item_t  pending_items [$];
  logic        inside_exp [$];
  plane_coef_t planes [NPL];
  test_item_t  offered;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          rx_hold = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned n_errors = 0;
  int unsigned n_loads = 0;
  int unsigned n_inside = 0;
  int unsigned n_outside = 0;

  int unsigned idle_tbl  [PHASE_NUM] = '{0, 54, 0, 26};
  int unsigned stall_tbl [PHASE_NUM] = '{0, 0, 54, 26};

  frustum_culling_test dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Signed distance of every stored plane, exact at 80 bits. The box uses the
  // corner farthest along each plane normal.
  function automatic logic inside_of(test_item_t it);
    logic signed [79:0] plane_dist;
    longint             ma, mb, mc;
    logic               verdict;
    verdict = 1'b1;
    for (int i = 0; i < NPL; i++) begin
      plane_dist = longint'(planes[i].a) * longint'(it.px)
                 + longint'(planes[i].b) * longint'(it.py)
                 + longint'(planes[i].c) * longint'(it.pz)
                 + longint'(planes[i].d) * longint'(65536);
      if (it.mode == MODE_SPHERE) begin
        plane_dist = plane_dist + longint'({1'b0, it.hx}) * longint'(65536);
      end else if (it.mode == MODE_BOX) begin
        ma = planes[i].a[CW-1] ? -longint'(planes[i].a) : longint'(planes[i].a);
        mb = planes[i].b[CW-1] ? -longint'(planes[i].b) : longint'(planes[i].b);
        mc = planes[i].c[CW-1] ? -longint'(planes[i].c) : longint'(planes[i].c);
        plane_dist = plane_dist + ma * longint'({1'b0, it.hx})
                   + mb * longint'({1'b0, it.hy}) + mc * longint'({1'b0, it.hz});
      end
      if (plane_dist[79]) verdict = 1'b0;
    end
    return verdict;
  endfunction

  // Applies one accepted item to the plane store or queues its expected flag.
  task automatic apply_item(test_item_t it);
    logic flag;
    if (it.mode == MODE_LOAD) begin
      n_loads++;
      if (it.idx < NPL) begin
        planes[it.idx].a = it.pa;
        planes[it.idx].b = it.pb;
        planes[it.idx].c = it.pc;
        planes[it.idx].d = it.pd;
      end
    end else begin
      flag = inside_of(it);
      inside_exp.push_back(flag);
      if (flag) n_inside++;
      else n_outside++;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_errors++;
  endtask

  // Mostly small signed values, sometimes full range or a corner value.
  function automatic logic [CW-1:0] rand_val(input int unsigned span);
    logic [CW-1:0] v;
    case ($urandom_range(9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(4))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = $urandom_range(0, 32'd2 << span) - (32'd1 << span);
    endcase
    return v;
  endfunction

  function automatic logic [CW-2:0] rand_half(input int unsigned span);
    logic [CW-2:0] v;
    case ($urandom_range(9))
      0: v = (CW - 1)'($urandom >> 1);
      1: v = $urandom_range(1) ? '1 : '0;
      default: v = (CW - 1)'($urandom_range(0, 32'd1 << span));
    endcase
    return v;
  endfunction

  task automatic push_load(input logic [INDEX_W-1:0] idx, input logic [CW-1:0] a,
                           input logic [CW-1:0] b, input logic [CW-1:0] c,
                           input logic [CW-1:0] d);
    test_item_t it;
    it.mode = MODE_LOAD;
    it.idx  = idx;
    it.pa = a; it.pb = b; it.pc = c; it.pd = d;
    it.px = $urandom; it.py = $urandom; it.pz = $urandom;
    it.hx = (CW - 1)'($urandom); it.hy = (CW - 1)'($urandom); it.hz = (CW - 1)'($urandom);
    pending_items.push_back(it);
  endtask

  task automatic push_test(input mode_t mode, input logic [CW-1:0] x, input logic [CW-1:0] y,
                           input logic [CW-1:0] z, input logic [CW-2:0] hx,
                           input logic [CW-2:0] hy, input logic [CW-2:0] hz);
    test_item_t it;
    it.mode = mode;
    it.idx  = INDEX_W'($urandom);
    it.pa = $urandom; it.pb = $urandom; it.pc = $urandom; it.pd = $urandom;
    it.px = x; it.py = y; it.pz = z;
    it.hx = hx; it.hy = hy; it.hz = hz;
    pending_items.push_back(it);
  endtask

  // Mostly tests against a plane set with small normals and mostly positive
  // offsets, with occasional full reloads, stray loads and wild values.
  task automatic push_random(input int unsigned count);
    logic [CW-1:0] d;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(79) == 0) begin
        for (int p = 0; p < NPL; p++) begin
          push_load(INDEX_W'(p), rand_val(17), rand_val(17), rand_val(17),
                    $urandom_range(0, 32'd1 << 22) - (32'd1 << 17));
        end
      end else if ($urandom_range(7) == 0) begin
        d = $urandom_range(3) == 0 ? rand_val(22)
                                   : $urandom_range(0, 32'd1 << 22) - (32'd1 << 17);
        push_load(INDEX_W'($urandom_range(15) == 0 ? $urandom_range(7)
                                                   : $urandom_range(NPL - 1)),
                  rand_val(17), rand_val(17), rand_val(17), d);
      end else begin
        push_test(mode_t'($urandom_range(MODE_POINT, MODE_BOX)), rand_val(20), rand_val(20),
                  rand_val(20), rand_half(18), rand_half(18), rand_half(18));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || s_axis_tvalid || inside_exp.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Input side: one item stays on the bus until its transfer.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) apply_item(offered);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= offered.mode;
          s_axis_tdata  <= {offered.hz, offered.hy, offered.hx, offered.pz, offered.py,
                            offered.px, offered.pd, offered.pc, offered.pb, offered.pa,
                            offered.idx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each result transfer, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (inside_exp.size() == 0) begin
          report_mismatch($sformatf("result %0b with no test outstanding", m_axis_tdata[0]));
        end else if (m_axis_tdata[0] !== inside_exp[0]) begin
          report_mismatch($sformatf("inside_res got %b expected %b",
                                    m_axis_tdata[0], inside_exp[0]));
          void'(inside_exp.pop_front());
        end else begin
          void'(inside_exp.pop_front());
        end
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > MAX_CYC) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < NPL; p++) planes[p] = '{default: '0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASE_NUM; ph++) begin
      @(negedge clk);
      send_idle_pct  = idle_tbl[ph];
      recv_stall_pct = stall_tbl[ph];
      if (ph == 0) begin
        // Cleared planes pass everything, even at the coordinate extremes.
        push_test(MODE_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0);
        push_test(MODE_SPHERE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '0, '1, '1);
        push_test(MODE_BOX, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '1, '1, '1);
        // Plane x >= 0: distances exactly zero must pass, slightly negative ones must fail.
        push_load(INDEX_W'(0), 32'h0001_0000, 32'h0, 32'h0, 32'h0);
        push_test(MODE_POINT, 32'h0, 32'h7fff_ffff, 32'h8000_0000, '1, '1, '1);
        push_test(MODE_POINT, 32'hffff_ffff, 32'h0, 32'h0, '1, '1, '1);
        push_test(MODE_SPHERE, 32'hffff_0000, 32'h0, 32'h0, 31'h0001_0000, '0, '0);
        push_test(MODE_SPHERE, 32'hffff_0000, 32'h0, 32'h0, 31'h0000_ffff, '1, '1);
        push_test(MODE_BOX, 32'hffff_0000, 32'h0, 32'h0, 31'h0001_0000, '0, '0);
        push_test(MODE_BOX, 32'hffff_0000, 32'h0, 32'h0, 31'h0000_ffff, '1, '1);
        // Loads past the last plane are dropped.
        push_load(INDEX_W'(6), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_load(INDEX_W'(7), 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000);
        push_test(MODE_POINT, 32'h0001_0000, 32'h7fff_ffff, 32'h7fff_ffff, '0, '0, '0);
        // Extreme coefficients on the last plane.
        push_load(INDEX_W'(NPL - 1), 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h8000_0000);
        push_test(MODE_POINT, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, '0, '0, '0);
        push_test(MODE_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0);
        push_test(MODE_SPHERE, 32'h0, 32'h0, 32'h0, '1, '0, '0);
        push_test(MODE_BOX, 32'h0, 32'h0, 32'h0, '1, '1, '1);
        push_test(MODE_BOX, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '0, '0, '0);
        // Restore every plane to a box around the origin.
        for (int p = 0; p < NPL; p++) begin
          push_load(INDEX_W'(p), p == 0 ? 32'h0001_0000 : p == 1 ? 32'hffff_0000 : 32'h0,
                    p == 2 ? 32'h0001_0000 : p == 3 ? 32'hffff_0000 : 32'h0,
                    p == 4 ? 32'h0001_0000 : p == 5 ? 32'hffff_0000 : 32'h0,
                    32'h0010_0000);
        end
        wait_drained();
      end
      // Receiver holds off long enough for the block to back up its input.
      if (ph == 0 || ph == 3) begin
        fork
          begin
            rx_hold = 1'b1;
            repeat (300) @(negedge clk);
            rx_hold = 1'b0;
          end
        join_none
      end
      push_random(PHASE_RND);
      wait_drained();
    end

    recv_stall_pct = 0;
    repeat (20) @(negedge clk);
    $display("Ran %0d plane loads and %0d tests (%0d inside, %0d outside)",
             n_loads, n_inside + n_outside, n_inside, n_outside);
    $display("across free-running, sender-idle, receiver-stall and mixed pacing phases.");
    if (n_errors == 0 && inside_exp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
